// File: hdl/ofr_pkg.sv
// Shared types, codes and helpers for the ordered fragment reassembler.
package ofr_pkg;

  localparam logic [10:0] MAX_PAYLOAD = 11'd1024;

  localparam logic KIND_ARRIVE  = 1'b0;
  localparam logic KIND_PROCESS = 1'b1;

  localparam logic [1:0] PT_WHOLE  = 2'd0;
  localparam logic [1:0] PT_FIRST  = 2'd1;
  localparam logic [1:0] PT_MIDDLE = 2'd2;
  localparam logic [1:0] PT_LAST   = 2'd3;

  localparam logic [1:0] RK_VERDICT = 2'd0;
  localparam logic [1:0] RK_DELIVER = 2'd1;
  localparam logic [1:0] RK_DISCARD = 2'd2;
  localparam logic [1:0] RK_DONE    = 2'd3;

  localparam logic [2:0] V_ACCEPTED  = 3'd0;
  localparam logic [2:0] V_STALE     = 3'd1;
  localparam logic [2:0] V_DUPLICATE = 3'd2;
  localparam logic [2:0] V_TOO_LONG  = 3'd3;
  localparam logic [2:0] V_FULL      = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  ptype;
    logic [10:0] len;
    logic [5:0]  slot;
  } entry_t;

  function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    if (d == 16'h8000) return a < b;
    return (d != 16'd0) && !d[15];
  endfunction

endpackage

// File: hdl/ordered_fragment_reassembler.sv
// Arrival checks use the shared entry compare, which walks one entry a cycle.
// A process pass walks the queue one entry a cycle, retrying an entry that breaks a run, then emits
// and shifts out one entry a cycle up to the newest complete message, then gives the pass done item.
// A new item is taken only when busy is low; the receiver cannot stall, results appear as strobes.
// Synchronous reset empties the queue and sets the last processed id to 65535.
module ordered_fragment_reassembler import ofr_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] packet_id,
  input  logic [1:0]  packet_type,
  input  logic [10:0] payload_length,
  input  logic [5:0]  payload_slot,
  output logic        valid,
  output logic [1:0]  result_kind,
  output logic [2:0]  verdict,
  output logic [5:0]  slot,
  output logic [10:0] length,
  output logic        message_end,
  output logic [5:0]  messages_count,
  output logic        last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAIL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  entry_t                 q [QUEUE_DEPTH];
  logic [2:0]             state;
  logic [CW-1:0]          count;
  logic [15:0]            last_id;
  logic [CW-1:0]          p;
  logic [CW-1:0]          pos;
  entry_t                 item;
  logic                   in_run;
  logic [15:0]            expect_id;
  logic [QUEUE_DEPTH-1:0] run;
  logic [QUEUE_DEPTH-1:0] dlv;
  logic [QUEUE_DEPTH-1:0] endm;
  logic [IW-1:0]          newest;
  logic                   have;
  logic [CW-1:0]          msgs;

  entry_t                 cur;
  logic [QUEUE_DEPTH-1:0] bitp;

  assign busy = (state != S_IDLE);
  assign cur  = q[p[IW-1:0]];
  assign bitp = {{(QUEUE_DEPTH-1){1'b0}}, 1'b1} << p[IW-1:0];

  always_ff @(posedge clk) begin
    valid          <= 1'b0;
    result_kind    <= RK_VERDICT;
    verdict        <= V_ACCEPTED;
    slot           <= item.slot;
    length         <= item.len;
    message_end    <= 1'b0;
    messages_count <= 6'd0;
    last           <= 1'b1;
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      last_id <= 16'hFFFF;
      in_run  <= 1'b0;
      have    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            item <= '{packet_id, packet_type, payload_length, payload_slot};
            slot   <= payload_slot;
            length <= payload_length;
            if (kind == KIND_PROCESS) begin
              p      <= '0;
              in_run <= 1'b0;
              have   <= 1'b0;
              msgs   <= '0;
              dlv    <= '0;
              endm   <= '0;
              run    <= '0;
              newest <= '0;
              state  <= S_WALK;
            end else if (payload_length > MAX_PAYLOAD) begin
              valid   <= 1'b1;
              verdict <= V_TOO_LONG;
            end else if (!seq_newer(packet_id, last_id)) begin
              valid   <= 1'b1;
              verdict <= V_STALE;
            end else if (count == '0) begin
              pos   <= '0;
              state <= S_INS;
            end else begin
              p     <= count - CW'(1);
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (!seq_newer(item.id, cur.id)) begin
            p     <= '0;
            state <= S_SCAN;
          end else begin
            pos   <= count;
            state <= S_INS;
          end
        end
        S_SCAN: begin
          if (p == count) begin
            pos   <= count;
            state <= S_INS;
          end else if (cur.id == item.id) begin
            valid   <= 1'b1;
            verdict <= V_DUPLICATE;
            state   <= S_IDLE;
          end else if (seq_newer(cur.id, item.id)) begin
            pos   <= p;
            state <= S_INS;
          end else begin
            p <= p + CW'(1);
          end
        end
        S_INS: begin
          valid <= 1'b1;
          state <= S_IDLE;
          if (count >= CW'(QUEUE_DEPTH)) begin
            verdict <= V_FULL;
          end else begin
            verdict <= V_ACCEPTED;
            for (int e = 1; e < QUEUE_DEPTH; e++) begin
              if ((CW'(e) > pos) && (CW'(e) <= count)) begin
                q[e] <= q[e-1];
              end
            end
            q[pos[IW-1:0]] <= item;
            count <= count + CW'(1);
          end
        end
        S_WALK: begin
          if (p == count) begin
            in_run <= 1'b0;
            state  <= have ? S_EMIT : S_FIN;
          end else if (!in_run) begin
            p <= p + CW'(1);
            if (cur.ptype == PT_WHOLE) begin
              dlv    <= dlv | bitp;
              endm   <= endm | bitp;
              newest <= p[IW-1:0];
              have   <= 1'b1;
              msgs   <= msgs + CW'(1);
            end else if (cur.ptype == PT_FIRST) begin
              in_run    <= 1'b1;
              run       <= bitp;
              expect_id <= cur.id + 16'd1;
            end
          end else if ((cur.id == expect_id) && (cur.ptype == PT_LAST)) begin
            dlv    <= dlv | run | bitp;
            endm   <= endm | bitp;
            newest <= p[IW-1:0];
            have   <= 1'b1;
            msgs   <= msgs + CW'(1);
            in_run <= 1'b0;
            p      <= p + CW'(1);
          end else if ((cur.id == expect_id) && (cur.ptype == PT_MIDDLE)) begin
            run       <= run | bitp;
            expect_id <= expect_id + 16'd1;
            p         <= p + CW'(1);
          end else begin
            in_run <= 1'b0;
          end
        end
        S_EMIT: begin
          valid       <= 1'b1;
          result_kind <= dlv[0] ? RK_DELIVER : RK_DISCARD;
          slot        <= q[0].slot;
          length      <= q[0].len;
          message_end <= endm[0];
          last        <= 1'b0;
          last_id     <= q[0].id;
          for (int e = 0; e < QUEUE_DEPTH - 1; e++) begin
            q[e] <= q[e+1];
          end
          dlv   <= dlv >> 1;
          endm  <= endm >> 1;
          count <= count - CW'(1);
          if (newest == '0) begin
            state <= S_FIN;
          end else begin
            newest <= newest - IW'(1);
          end
        end
        S_FIN: begin
          valid          <= 1'b1;
          result_kind    <= RK_DONE;
          slot           <= 6'd0;
          length         <= 11'd0;
          messages_count <= 6'(msgs);
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/ordered_fragment_reassembler_tb.sv
// Self-checking testbench for the ordered fragment reassembler: directed table, then random traffic.
`timescale 1ns / 100ps

module ordered_fragment_reassembler_tb;
  import ofr_pkg::*;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic [1:0]  rk;
    logic [2:0]  vd;
    logic [5:0]  sl;
    logic [10:0] ln;
    logic        mend;
    logic [5:0]  cnt;
    logic        lst;
  } outcome_t;

  typedef struct {
    logic        k;
    logic [15:0] id;
    logic [1:0]  pt;
    logic [10:0] ln;
    logic [5:0]  sl;
    bit          typed;
    logic [2:0]  vd;
  } packet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [15:0] packet_id = '0;
  logic [1:0]  packet_type = '0;
  logic [10:0] payload_length = '0;
  logic [5:0]  payload_slot = '0;
  logic        valid;
  logic [1:0]  result_kind;
  logic [2:0]  verdict;
  logic [5:0]  slot;
  logic [10:0] length;
  logic        message_end;
  logic [5:0]  messages_count;
  logic        last;

  ordered_fragment_reassembler u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .packet_id(packet_id), .packet_type(packet_type), .payload_length(payload_length),
    .payload_slot(payload_slot), .valid(valid), .result_kind(result_kind),
    .verdict(verdict), .slot(slot), .length(length), .message_end(message_end),
    .messages_count(messages_count), .last(last)
  );

  always #2 clk = ~clk;

  // Shadow copy of the reorder queue.
  logic [15:0] q_id [DEPTH];
  logic [1:0]  q_pt [DEPTH];
  logic [10:0] q_ln [DEPTH];
  logic [5:0]  q_sl [DEPTH];
  int          q_count = 0;
  logic [15:0] last_done_id = 16'hFFFF;

  outcome_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int delivered = 0;
  int full_hits = 0;
  bit quiet = 1'b0;

  function automatic bit is_later(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    if (d == 16'h8000) return a < b;
    return (d != 16'd0) && (d < 16'h8000);
  endfunction

  function automatic outcome_t mk(input logic [1:0] rk, input logic [2:0] vd,
                                  input logic [5:0] sl, input logic [10:0] ln,
                                  input logic mend, input logic [5:0] cnt, input logic lst);
    outcome_t o;
    o.rk = rk; o.vd = vd; o.sl = sl; o.ln = ln; o.mend = mend; o.cnt = cnt; o.lst = lst;
    return o;
  endfunction

  function automatic void expect_result(input outcome_t o);
    pending_results = {pending_results, o};
  endfunction

  task automatic predict_arrival(input packet_t p);
    logic [2:0] v;
    int pos;
    bit dup;
    v = V_ACCEPTED;
    dup = 1'b0;
    pos = q_count;
    if (p.ln > MAX_PAYLOAD) begin
      v = V_TOO_LONG;
    end else if (!is_later(p.id, last_done_id)) begin
      v = V_STALE;
    end else begin
      if (q_count != 0 && !is_later(p.id, q_id[q_count-1])) begin
        for (int i = 0; i < q_count; i++) begin
          if (q_id[i] == p.id) begin
            dup = 1'b1; pos = i; break;
          end
          if (is_later(q_id[i], p.id)) begin
            pos = i; break;
          end
        end
      end
      if (dup) begin
        v = V_DUPLICATE;
      end else if (q_count >= DEPTH) begin
        v = V_FULL;
      end else begin
        for (int i = q_count; i > pos; i--) begin
          q_id[i] = q_id[i-1]; q_pt[i] = q_pt[i-1]; q_ln[i] = q_ln[i-1]; q_sl[i] = q_sl[i-1];
        end
        q_id[pos] = p.id; q_pt[pos] = p.pt; q_ln[pos] = p.ln; q_sl[pos] = p.sl;
        q_count++;
      end
    end
    if (v == V_FULL) full_hits++;
    expect_result(mk(RK_VERDICT, v, p.sl, p.ln, 1'b0, 6'd0, 1'b1));
  endtask

  task automatic predict_pass();
    int mark [DEPTH];
    int i, j, newest, msgs, n;
    bit have, ok;
    logic [15:0] want;
    i = 0; newest = 0; msgs = 0; have = 1'b0;
    for (int k = 0; k < DEPTH; k++) mark[k] = 0;
    while (i < q_count) begin
      if (q_pt[i] == PT_WHOLE) begin
        mark[i] = 2; newest = i; have = 1'b1; msgs++; i++;
      end else if (q_pt[i] == PT_FIRST) begin
        want = q_id[i] + 16'd1;
        ok = 1'b0;
        j = i + 1;
        while (j < q_count && q_id[j] == want) begin
          if (q_pt[j] == PT_LAST) begin
            ok = 1'b1; break;
          end
          if (q_pt[j] != PT_MIDDLE) break;
          j++;
          want = want + 16'd1;
        end
        if (ok) begin
          for (int k = i; k < j; k++) mark[k] = 1;
          mark[j] = 2; newest = j; have = 1'b1; msgs++; i = j + 1;
        end else begin
          i = j;
        end
      end else begin
        i++;
      end
    end
    if (have) begin
      for (int k = 0; k <= newest; k++) begin
        if (mark[k] != 0) begin
          expect_result(mk(RK_DELIVER, V_ACCEPTED, q_sl[k], q_ln[k],
                           mark[k] == 2, 6'd0, 1'b0));
          delivered++;
        end else begin
          expect_result(mk(RK_DISCARD, V_ACCEPTED, q_sl[k], q_ln[k],
                           1'b0, 6'd0, 1'b0));
        end
      end
      last_done_id = q_id[newest];
      n = newest + 1;
      for (int k = n; k < q_count; k++) begin
        q_id[k-n] = q_id[k]; q_pt[k-n] = q_pt[k]; q_ln[k-n] = q_ln[k]; q_sl[k-n] = q_sl[k];
      end
      q_count -= n;
    end
    expect_result(mk(RK_DONE, V_ACCEPTED, 6'd0, 11'd0, 1'b0, msgs[5:0], 1'b1));
  endtask

  task automatic send(input packet_t p);
    @(negedge clk);
    start <= 1'b1;
    kind <= p.k;
    packet_id <= p.id;
    packet_type <= p.pt;
    payload_length <= p.ln;
    payload_slot <= p.sl;
    do @(posedge clk); while (busy);
    items_sent++;
    if (p.k == KIND_PROCESS) begin
      predict_pass();
    end else begin
      predict_arrival(p);
      if (p.typed) begin
        pending_results[$] = mk(RK_VERDICT, p.vd, p.sl, p.ln, 1'b0, 6'd0, 1'b1);
      end
    end
  endtask

  task automatic pause_maybe();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 9);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic packet_t pk(input logic k, input logic [15:0] id, input logic [1:0] pt,
                                 input logic [10:0] ln, input logic [5:0] sl);
    packet_t p;
    p.k = k; p.id = id; p.pt = pt; p.ln = ln; p.sl = sl; p.typed = 1'b0; p.vd = V_ACCEPTED;
    return p;
  endfunction

  function automatic packet_t pkv(input logic [15:0] id, input logic [1:0] pt,
                                  input logic [10:0] ln, input logic [5:0] sl,
                                  input logic [2:0] vd);
    packet_t p;
    p = pk(KIND_ARRIVE, id, pt, ln, sl);
    p.typed = 1'b1;
    p.vd = vd;
    return p;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: kind %0d slot %0d", result_kind, slot);
      end else begin
        e = pending_results.pop_front();
        if (result_kind !== e.rk || verdict !== e.vd || slot !== e.sl || length !== e.ln ||
            message_end !== e.mend || messages_count !== e.cnt || last !== e.lst) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected kind %0d verdict %0d slot %0d len %0d end %0d cnt %0d last %0d",
                     e.rk, e.vd, e.sl, e.ln, e.mend, e.cnt, e.lst);
            $display("          actual   kind %0d verdict %0d slot %0d len %0d end %0d cnt %0d last %0d",
                     result_kind, verdict, slot, length, message_end, messages_count, last);
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("ordered_fragment_reassembler_tb: done, errors");
    $finish;
  end

  initial begin
    packet_t table_rows [$];
    packet_t msg [$];
    packet_t tmp;
    logic [15:0] next_id;
    int r, n, full_bursts, random_start, drop;
    bit paused;

    table_rows = '{
      pkv(16'd0, PT_WHOLE, 11'd1024, 6'd63, V_ACCEPTED),
      pkv(16'd1, PT_WHOLE, 11'd1025, 6'd1, V_TOO_LONG),
      pkv(16'hFFFF, PT_WHOLE, 11'd0, 6'd2, V_STALE),
      pkv(16'd0, PT_FIRST, 11'd5, 6'd3, V_DUPLICATE),
      pkv(16'd5, PT_FIRST, 11'd0, 6'd4, V_ACCEPTED),
      pkv(16'd6, PT_MIDDLE, 11'd0, 6'd5, V_ACCEPTED),
      pkv(16'd7, PT_LAST, 11'd0, 6'd6, V_ACCEPTED),
      pkv(16'd3, PT_FIRST, 11'd10, 6'd7, V_ACCEPTED),
      pkv(16'd10, PT_MIDDLE, 11'd20, 6'd8, V_ACCEPTED),
      pkv(16'd2, PT_WHOLE, 11'd2047, 6'd9, V_TOO_LONG),
      pkv(16'd12, PT_LAST, 11'd1, 6'd10, V_ACCEPTED),
      pkv(16'd14, PT_FIRST, 11'd30, 6'd11, V_ACCEPTED),
      pkv(16'd15, PT_WHOLE, 11'd40, 6'd12, V_ACCEPTED),
      pkv(16'd9, PT_FIRST, 11'd50, 6'd13, V_ACCEPTED),
      pk(KIND_PROCESS, 16'hFFFF, PT_LAST, 11'h7FF, 6'd63),
      pk(KIND_PROCESS, 16'd0, PT_WHOLE, 11'd0, 6'd0),
      pkv(16'd0, PT_WHOLE, 11'd7, 6'd14, V_STALE),
      pkv(16'd32782, PT_WHOLE, 11'd8, 6'd15, V_ACCEPTED),
      pkv(16'd32783, PT_WHOLE, 11'd9, 6'd16, V_STALE),
      pk(KIND_ARRIVE, 16'd16, PT_WHOLE, 11'd11, 6'd17),
      pk(KIND_PROCESS, 16'd0, PT_WHOLE, 11'd0, 6'd0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send(table_rows[i]);

    next_id = 16'd32800;
    full_bursts = 0;
    paused = 1'b0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      quiet = (items_sent - random_start) > RANDOM_ITEMS - 40;
      if (!paused && items_sent - random_start > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      msg.delete();
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) next_id = 16'(next_id + $urandom_range(1, 20000));
      if (r < 5 && full_bursts < 2) begin
        full_bursts++;
        for (int k = 0; k < DEPTH + 2; k++) begin
          msg = {msg, pk(KIND_ARRIVE, next_id, PT_WHOLE, 11'($urandom_range(0, 1024)),
                         6'($urandom_range(0, 63)))};
          next_id++;
        end
        msg = {msg, pk(KIND_PROCESS, 16'($urandom), 2'($urandom), 11'($urandom),
                       6'($urandom))};
      end else if (r < 20) begin
        msg = {msg, pk(KIND_PROCESS, 16'($urandom), 2'($urandom), 11'($urandom),
                       6'($urandom))};
      end else if (r < 30) begin
        tmp = pk(KIND_ARRIVE, 16'($urandom), 2'($urandom), 11'($urandom_range(0, 2047)),
                 6'($urandom));
        if ($urandom_range(0, 1)) tmp.id = 16'(next_id - $urandom_range(0, 40));
        msg = {msg, tmp};
      end else begin
        n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 5);
        for (int k = 0; k < n; k++) begin
          tmp = pk(KIND_ARRIVE, next_id + k[15:0], PT_MIDDLE, 11'($urandom_range(0, 1024)),
                   6'($urandom_range(0, 63)));
          if (n == 1) tmp.pt = PT_WHOLE;
          else if (k == 0) tmp.pt = PT_FIRST;
          else if (k == n - 1) tmp.pt = PT_LAST;
          if ($urandom_range(0, 15) == 0) tmp.ln = $urandom_range(0, 1) ? 11'd0 : 11'd1024;
          msg = {msg, tmp};
        end
        if (n > 1 && $urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, n - 2);
          tmp = msg[r]; msg[r] = msg[r+1]; msg[r+1] = tmp;
        end
        if (n > 1 && $urandom_range(0, 5) == 0) begin
          drop = $urandom_range(0, n - 1);
          msg.delete(drop);
        end
        next_id = 16'(next_id + n + (($urandom_range(0, 7) == 0) ? 1 : 0));
      end
      foreach (msg[i]) begin
        pause_maybe();
        send(msg[i]);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Run covered %0d items and %0d results: %0d slots delivered, %0d queue-full verdicts.",
             items_sent, results_seen, delivered, full_hits);
    if (errors == 0) begin
      $display("ordered_fragment_reassembler_tb: done, clean");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("ordered_fragment_reassembler_tb: done, errors");
    end
    $finish;
  end

endmodule
